/* hdl/multi_timer_scheduler_assert.svh */
// Assertion macros used by the timer scheduler checker
`ifndef MULTI_TIMER_SCHEDULER_ASSERT_SVH
`define MULTI_TIMER_SCHEDULER_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define MTS_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during rst
`define MTS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mts_pkg.sv */
// Package: constants, opcodes and state encoding of the timer scheduler
`timescale 1ns / 1ps
package mts_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int TIME_BITS_DEF  = 48;
  localparam int MAX_RESULTS    = 16;
  localparam int OPCODE_W       = 3;
  localparam int SLOT_ID_W      = 4;
  localparam int PERIOD_W       = 32;
  localparam int TICKS_W        = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_START   = 3'd0,
    OP_STOP    = 3'd1,
    OP_RESTART = 3'd2,
    OP_TICK    = 3'd3,
    OP_QUERY   = 3'd4
  } opcode_t;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESTART,
    ST_SCAN,
    ST_DECIDE
  } state_t;

endpackage

/* hdl/mts_req_if.sv */
// Request channel of the timer scheduler
`timescale 1ns / 1ps
interface mts_req_if import mts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [SLOT_ID_W-1:0] slot_id;
  logic [PERIOD_W-1:0]  period_ticks;
  logic                 one_shot;

  modport source (output valid, output opcode, output slot_id, output period_ticks,
                  output one_shot, input ready);
  modport sink (input valid, input opcode, input slot_id, input period_ticks,
                input one_shot, output ready);
endinterface

/* hdl/mts_res_if.sv */
// Result channel of the timer scheduler
`timescale 1ns / 1ps
interface mts_res_if import mts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 result_kind;
  logic [SLOT_ID_W-1:0] fired_slot;
  logic [TICKS_W-1:0]   ticks_to_next;
  logic                 nothing_pending;
  logic                 last_of_run;

  modport source (output valid, output result_kind, output fired_slot,
                  output ticks_to_next, output nothing_pending, output last_of_run,
                  input ready);
  modport sink (input valid, input result_kind, input fired_slot, input ticks_to_next,
                input nothing_pending, input last_of_run, output ready);
endinterface

/* hdl/mts_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/multi_timer_scheduler.sv */
// Top level: table of one-shot and periodic timer slots driven by a tick count
//
// Requests arrive on req (valid/ready); results leave on res (valid/ready).
// Start and stop are done on acceptance. Restart reads the slot's
// interval from the period memory, then writes the new deadline.
// Query scans every slot once through the deadline and period memories,
// one slot a cycle, and answers once the output register is free.
// Tick advances time and runs one scan pass for each slot it fires plus
// one final pass. Each pass picks the earliest due slot, ties to the
// lower slot, and rearms or stops it. Every event is held back one pass
// so the final one can carry last_of_run.
// req.ready is high only between requests. A result waits in the output
// register while res.ready is low; the scan holds before overwriting it.
// Reset clears the time count and all live marks; memory contents are left
// as they are and used only for live slots.
`timescale 1ns / 1ps
module multi_timer_scheduler import mts_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mts_req_if.sink   req,
  mts_res_if.source res
);

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int FIRE_W = $clog2(MAX_RESULTS + 1);
  localparam int PD_W   = PERIOD_W + 1;
  localparam logic [TIME_BITS-1:0] TIME_TOP  = {1'b1, {(TIME_BITS-1){1'b0}}};
  localparam logic [TIME_BITS-1:0] TICKS_SAT = TIME_BITS'({TICKS_W{1'b1}});

  state_t state, state_next;

  logic [TIME_BITS-1:0]  now;
  logic [SLOT_COUNT-1:0] live;
  logic [SLOT_COUNT-1:0] done;
  logic [CNT_W-1:0]      cnt;
  logic                  mode_tick;
  logic                  found;
  logic [IDX_W-1:0]      best_slot;
  logic [TIME_BITS-1:0]  best_key;
  logic [PERIOD_W-1:0]   best_period;
  logic                  best_one_shot;
  logic                  have_pend;
  logic [IDX_W-1:0]      pend_slot;
  logic [FIRE_W-1:0]     fire_count;
  logic [IDX_W-1:0]      rs_slot;

  logic                  res_valid;
  logic                  res_kind;
  logic [SLOT_ID_W-1:0]  res_slot;
  logic [TICKS_W-1:0]    res_ticks;
  logic                  res_none;
  logic                  res_last;

  logic                  dl_we;
  logic [IDX_W-1:0]      dl_waddr;
  logic [TIME_BITS-1:0]  dl_wdata;
  logic [TIME_BITS-1:0]  dl_rdata;
  logic                  pd_we;
  logic [PD_W-1:0]       pd_wdata;
  logic [PD_W-1:0]       pd_rdata;
  logic [IDX_W-1:0]      rd_addr;

  logic                  req_fire;
  logic                  slot_ok;
  logic [IDX_W-1:0]      slot_idx;
  logic                  out_free;
  logic [PERIOD_W-1:0]   addend;

  logic                  proc_valid;
  logic [IDX_W-1:0]      proc_slot;
  logic [TIME_BITS-1:0]  gap;
  logic                  due;
  logic                  cand;
  logic [TIME_BITS-1:0]  key;
  logic                  take;

  logic                  start_scan;
  logic                  fire;
  logic                  push;
  logic                  push_kind;
  logic [SLOT_ID_W-1:0]  push_slot;
  logic [TICKS_W-1:0]    push_ticks;
  logic                  push_none;
  logic                  push_last;
  logic                  set_live;
  logic                  clr_live;
  logic [IDX_W-1:0]      live_idx;

  mts_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOT_COUNT)) u_deadline_ram (
    .clk     (clk),
    .wr_en   (dl_we),
    .wr_addr (dl_waddr),
    .wr_data (dl_wdata),
    .rd_addr (rd_addr),
    .rd_data (dl_rdata)
  );

  mts_ram #(.WIDTH(PD_W), .DEPTH(SLOT_COUNT)) u_period_ram (
    .clk     (clk),
    .wr_en   (pd_we),
    .wr_addr (dl_waddr),
    .wr_data (pd_wdata),
    .rd_addr (rd_addr),
    .rd_data (pd_rdata)
  );

  assign req.ready           = (state == ST_IDLE);
  assign res.valid           = res_valid;
  assign res.result_kind     = res_kind;
  assign res.fired_slot      = res_slot;
  assign res.ticks_to_next   = res_ticks;
  assign res.nothing_pending = res_none;
  assign res.last_of_run     = res_last;

  assign req_fire = req.valid && req.ready;
  assign slot_ok  = int'(req.slot_id) < SLOT_COUNT;
  assign slot_idx = IDX_W'(req.slot_id);
  assign out_free = !res_valid || res.ready;
  assign rd_addr  = (state == ST_IDLE) ? slot_idx : IDX_W'(cnt);
  assign pd_wdata = {req.one_shot, req.period_ticks};

  // per-slot compare on the data read in the previous cycle
  assign proc_valid = (state == ST_SCAN) && (cnt != '0);
  assign proc_slot  = IDX_W'(cnt - CNT_W'(1));
  assign gap        = dl_rdata - now;
  assign due        = (gap == '0) || gap[TIME_BITS-1];
  assign cand       = mode_tick ? (live[proc_slot] && !done[proc_slot] && due)
                                : live[proc_slot];
  assign key        = mode_tick ? (gap ^ TIME_TOP) : (due ? '0 : gap);
  assign take       = proc_valid && cand && (!found || key < best_key);

  assign dl_wdata = now + TIME_BITS'(addend);

  always_comb begin
    state_next = state;
    dl_we      = 1'b0;
    pd_we      = 1'b0;
    dl_waddr   = slot_idx;
    addend     = req.period_ticks;
    start_scan = 1'b0;
    fire       = 1'b0;
    push       = 1'b0;
    push_kind  = KIND_EXPIRY;
    push_slot  = SLOT_ID_W'(pend_slot);
    push_ticks = '0;
    push_none  = 1'b0;
    push_last  = 1'b0;
    set_live   = 1'b0;
    clr_live   = 1'b0;
    live_idx   = slot_idx;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          unique case (req.opcode)
            OP_START: begin
              if (slot_ok) begin
                dl_we    = 1'b1;
                pd_we    = 1'b1;
                set_live = 1'b1;
              end
            end
            OP_STOP: begin
              clr_live = slot_ok;
            end
            OP_RESTART: begin
              if (slot_ok && live[slot_idx]) begin
                state_next = ST_RESTART;
              end
            end
            OP_TICK, OP_QUERY: begin
              start_scan = 1'b1;
              state_next = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RESTART: begin
        dl_we      = 1'b1;
        dl_waddr   = rs_slot;
        addend     = pd_rdata[PERIOD_W-1:0];
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (cnt == CNT_W'(SLOT_COUNT)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!mode_tick) begin
          if (out_free) begin
            push       = 1'b1;
            push_kind  = KIND_QUERY;
            push_slot  = '0;
            push_ticks = !found ? '0 :
                         (best_key > TICKS_SAT) ? {TICKS_W{1'b1}} : best_key[TICKS_W-1:0];
            push_none  = !found;
            push_last  = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (found && int'(fire_count) < MAX_RESULTS) begin
          if (!have_pend || out_free) begin
            push       = have_pend;
            fire       = 1'b1;
            dl_waddr   = best_slot;
            addend     = best_period;
            dl_we      = !best_one_shot;
            clr_live   = best_one_shot;
            live_idx   = best_slot;
            state_next = ST_SCAN;
          end
        end else if (!have_pend) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now        <= '0;
      live       <= '0;
      done       <= '0;
      cnt        <= '0;
      mode_tick  <= 1'b0;
      found      <= 1'b0;
      have_pend  <= 1'b0;
      fire_count <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (set_live) begin
        live[live_idx] <= 1'b1;
      end
      if (clr_live) begin
        live[live_idx] <= 1'b0;
      end
      if (start_scan) begin
        mode_tick  <= (req.opcode == OP_TICK);
        cnt        <= '0;
        found      <= 1'b0;
        done       <= '0;
        have_pend  <= 1'b0;
        fire_count <= '0;
        if (req.opcode == OP_TICK) begin
          now <= now + TIME_BITS'(1);
        end
      end
      if (state == ST_SCAN) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (take) begin
        found <= 1'b1;
      end
      if (fire) begin
        done[best_slot] <= 1'b1;
        have_pend       <= 1'b1;
        fire_count      <= fire_count + FIRE_W'(1);
        cnt             <= '0;
        found           <= 1'b0;
      end
      if (push) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rs_slot <= slot_idx;
    end
    if (take) begin
      best_slot     <= proc_slot;
      best_key      <= key;
      best_period   <= pd_rdata[PERIOD_W-1:0];
      best_one_shot <= pd_rdata[PERIOD_W];
    end
    if (fire) begin
      pend_slot <= best_slot;
    end
    if (push) begin
      res_kind  <= push_kind;
      res_slot  <= push_slot;
      res_ticks <= push_ticks;
      res_none  <= push_none;
      res_last  <= push_last;
    end
  end

endmodule

/* hdl/mts_checker.sv */
// Port-level checks of the timer scheduler, bound to the top level
`timescale 1ns / 1ps
`include "multi_timer_scheduler_assert.svh"
module mts_checker import mts_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic [OPCODE_W-1:0]  req_opcode,
  input logic                 res_valid,
  input logic                 res_ready,
  input logic                 res_result_kind,
  input logic [SLOT_ID_W-1:0] res_fired_slot,
  input logic [TICKS_W-1:0]   res_ticks_to_next,
  input logic                 res_nothing_pending,
  input logic                 res_last_of_run
);

  `MTS_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_result_kind) && $stable(res_fired_slot) && $stable(res_ticks_to_next) && $stable(res_last_of_run), "stalled result changed")
  `MTS_IMPLIES(a_query_last, res_valid && res_result_kind == KIND_QUERY, res_last_of_run && res_fired_slot == '0, "query answer not a single last result")
  `MTS_IMPLIES(a_query_none, res_valid && res_result_kind == KIND_QUERY && res_nothing_pending, res_ticks_to_next == '0, "empty query reports ticks")
  `MTS_IMPLIES(a_expiry_clean, res_valid && res_result_kind == KIND_EXPIRY, res_ticks_to_next == '0 && !res_nothing_pending, "expiry event carries query fields")
  `MTS_NEXT(a_query_busy, req_valid && req_ready && req_opcode == OP_QUERY, !req_ready, "request taken during query scan")

endmodule

bind multi_timer_scheduler mts_checker u_mts_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .req_opcode          (req.opcode),
  .res_valid           (res.valid),
  .res_ready           (res.ready),
  .res_result_kind     (res.result_kind),
  .res_fired_slot      (res.fired_slot),
  .res_ticks_to_next   (res.ticks_to_next),
  .res_nothing_pending (res.nothing_pending),
  .res_last_of_run     (res.last_of_run)
);
